FILE: rtl/core/pesu_pkg.sv
// Shared widths, constants and pipeline tag type for the plane equation setup unit.
`default_nettype none
package pesu_pkg;

  // coordinate and intermediate widths
  localparam int CoordW    = 16;
  localparam int DiffW     = CoordW + 1;
  localparam int ProdW     = 2 * DiffW;
  localparam int NormW     = ProdW + 1;
  localparam int MagW      = NormW - 1;
  localparam int PosW      = $clog2(MagW);

  // normalisation: largest magnitude brought into [2^ShiftTop, 2^(ShiftTop+1))
  localparam int ShiftTop  = 29;
  localparam int ScW       = ShiftTop + 1;
  localparam int SqW       = 2 * ScW;
  localparam int SumW      = SqW + 2;
  localparam int RootW     = SumW / 2;
  localparam int ResW      = SumW + 1;

  // division and coefficients
  localparam int NormFrac  = 15;
  localparam int CoefW     = 16;
  localparam int QW        = NormFrac + 2;
  localparam int DW        = RootW + 1;
  localparam int RemW      = DW + QW - 1;
  localparam int LimitRaw  = (1 << NormFrac) - 1;
  localparam int LimitInt  = (LimitRaw > 32767) ? 32767 : LimitRaw;
  localparam logic [QW-1:0] CoefLimit = QW'(LimitInt);

  // offset
  localparam int OffW      = 32;
  localparam int PdW       = CoefW + CoordW;
  localparam int OffSumW   = PdW + 2;
  localparam logic signed [OffSumW-1:0] OffHi =
    {{(OffSumW-OffW+1){1'b0}}, {(OffW-1){1'b1}}};
  localparam logic signed [OffSumW-1:0] OffLo =
    {{(OffSumW-OffW+1){1'b1}}, {(OffW-1){1'b0}}};

  // side data that travels with every item
  typedef struct packed {
    logic                   valid;
    logic                   deg;
    logic [2:0]             neg;
    logic [2:0][CoordW-1:0] p0;
  } tag_t;

endpackage
`default_nettype wire

FILE: rtl/core/plane_equation_setup_unit.sv
// Plane equation setup unit: top level joining the front, root, divider and back pipelines.
//
// Input channel (in_valid_i / in_ready_o) carries a mode bit and three
// points. Mode 0 builds the plane through p0, p1, p2; mode 1 uses p0 and
// the normal p1. Output channel (out_valid_o / out_ready_i) returns one
// unit normal in Q1.15 (coef_a/b/c) and offset coef_d = -n.p0 in Q17.15,
// with degenerate_o set and all coefficients zero for a zero normal.
// The pipeline has 9 front stages (cross product, normalising shift,
// squares), 31 square root stages (one root bit each), 17 divider stages
// (one quotient bit each) and 3 back stages ending in the output register.
// Throughput is one transfer per cycle once the pipeline is full and the receiver takes every result.
// The whole pipeline advances together; while the receiver holds off a
// valid result every stage holds, in_ready_o drops and nothing is lost.
// An empty output slot never stalls the pipeline, but bubbles inside it are not squeezed out.
// Reset clears every tag register, valid bits included; datapath registers are not reset.
`default_nettype none
module plane_equation_setup_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               mode_i,
  input  wire logic signed [pesu_pkg::CoordW-1:0] p0_x_i,
  input  wire logic signed [pesu_pkg::CoordW-1:0] p0_y_i,
  input  wire logic signed [pesu_pkg::CoordW-1:0] p0_z_i,
  input  wire logic signed [pesu_pkg::CoordW-1:0] p1_x_i,
  input  wire logic signed [pesu_pkg::CoordW-1:0] p1_y_i,
  input  wire logic signed [pesu_pkg::CoordW-1:0] p1_z_i,
  input  wire logic signed [pesu_pkg::CoordW-1:0] p2_x_i,
  input  wire logic signed [pesu_pkg::CoordW-1:0] p2_y_i,
  input  wire logic signed [pesu_pkg::CoordW-1:0] p2_z_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [pesu_pkg::CoefW-1:0]       coef_a_o,
  output logic signed [pesu_pkg::CoefW-1:0]       coef_b_o,
  output logic signed [pesu_pkg::CoefW-1:0]       coef_c_o,
  output logic signed [pesu_pkg::OffW-1:0]        coef_d_o,
  output logic                                    degenerate_o
);

  logic                                  en;
  logic [2:0][pesu_pkg::CoordW-1:0]      p0, p1, p2;
  pesu_pkg::tag_t                        f_tag, s_tag, d_tag;
  logic [2:0][pesu_pkg::ScW-1:0]         f_mag, s_mag;
  logic [pesu_pkg::SumW-1:0]             f_sum;
  logic [pesu_pkg::RootW-1:0]            s_root;
  logic [2:0][pesu_pkg::QW-1:0]          d_quo;
  logic [2:0][pesu_pkg::CoefW-1:0]       coef;
  logic [pesu_pkg::OffW-1:0]             off;

  // global advance: the output slot is empty or being taken
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  assign p0 = {p0_z_i, p0_y_i, p0_x_i};
  assign p1 = {p1_z_i, p1_y_i, p1_x_i};
  assign p2 = {p2_z_i, p2_y_i, p2_x_i};

  pesu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .mode_i  (mode_i),
    .p0_i    (p0),
    .p1_i    (p1),
    .p2_i    (p2),
    .tag_o   (f_tag),
    .mag_o   (f_mag),
    .sum_o   (f_sum)
  );

  pesu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (f_tag),
    .mag_i  (f_mag),
    .sum_i  (f_sum),
    .tag_o  (s_tag),
    .mag_o  (s_mag),
    .root_o (s_root)
  );

  pesu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (s_tag),
    .mag_i  (s_mag),
    .root_i (s_root),
    .tag_o  (d_tag),
    .quo_o  (d_quo)
  );

  pesu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tag_i   (d_tag),
    .quo_i   (d_quo),
    .valid_o (out_valid_o),
    .coef_o  (coef),
    .off_o   (off),
    .deg_o   (degenerate_o)
  );

  assign coef_a_o = coef[0];
  assign coef_b_o = coef[1];
  assign coef_c_o = coef[2];
  assign coef_d_o = off;

endmodule
`default_nettype wire

FILE: rtl/core/pesu_front.sv
// Front pipeline: edge vectors, cross product, magnitudes, normalising shift, sum of squares.
`default_nettype none
module pesu_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic                             valid_i,
  input  wire logic                             mode_i,
  input  wire logic [2:0][pesu_pkg::CoordW-1:0] p0_i,
  input  wire logic [2:0][pesu_pkg::CoordW-1:0] p1_i,
  input  wire logic [2:0][pesu_pkg::CoordW-1:0] p2_i,
  output pesu_pkg::tag_t                        tag_o,
  output logic [2:0][pesu_pkg::ScW-1:0]         mag_o,
  output logic [pesu_pkg::SumW-1:0]             sum_o
);

  pesu_pkg::tag_t t0, t1_q, t2_q, t3_q, t4_q, t4_d, t5_q, t5_d, t6_q, t7_q, t8_q, t9_q;

  logic signed [pesu_pkg::DiffW-1:0]  u_q [3];
  logic signed [pesu_pkg::DiffW-1:0]  w_q [3];
  logic signed [pesu_pkg::CoordW-1:0] n1_q [3];
  logic signed [pesu_pkg::CoordW-1:0] n2_q [3];
  logic                               mode1_q, mode2_q;
  logic signed [pesu_pkg::ProdW-1:0]  pr_q [6];
  logic signed [pesu_pkg::NormW-1:0]  nv_q [3];
  logic [pesu_pkg::MagW-1:0]          mag4_q [3];
  logic [pesu_pkg::MagW-1:0]          mag5_q [3];
  logic [pesu_pkg::MagW-1:0]          mag6_q [3];
  logic [pesu_pkg::MagW-1:0]          max_q;
  logic [pesu_pkg::MagW-1:0]          max_d;
  logic [pesu_pkg::PosW-1:0]          pos;
  logic [pesu_pkg::PosW-1:0]          rsh_q, lsh_q, rsh_d, lsh_d;
  logic [pesu_pkg::ScW-1:0]           sc7_q [3];
  logic [pesu_pkg::ScW-1:0]           sc8_q [3];
  logic [pesu_pkg::ScW-1:0]           sc9_q [3];
  logic [pesu_pkg::SqW-1:0]           sq_q [3];
  logic [pesu_pkg::SumW-1:0]          sum_q;

  always_comb begin
    t0       = '0;
    t0.valid = valid_i;
    t0.p0    = p0_i;
  end

  // sign bits of the normal
  always_comb begin
    t4_d = t3_q;
    for (int k = 0; k < 3; k++) begin
      t4_d.neg[k] = nv_q[k][pesu_pkg::NormW-1];
    end
  end

  // largest magnitude and zero normal
  always_comb begin
    max_d = mag4_q[0];
    if (mag4_q[1] > max_d) max_d = mag4_q[1];
    if (mag4_q[2] > max_d) max_d = mag4_q[2];
    t5_d     = t4_q;
    t5_d.deg = (max_d == '0);
  end

  // leading one position and the shift it implies
  always_comb begin
    pos = '0;
    for (int i = 0; i < pesu_pkg::MagW; i++) begin
      if (max_q[i]) pos = pesu_pkg::PosW'(i);
    end
    rsh_d = '0;
    lsh_d = '0;
    if (pos > pesu_pkg::PosW'(pesu_pkg::ShiftTop)) begin
      rsh_d = pos - pesu_pkg::PosW'(pesu_pkg::ShiftTop);
    end else begin
      lsh_d = pesu_pkg::PosW'(pesu_pkg::ShiftTop) - pos;
    end
  end

  // tag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0; t2_q <= '0; t3_q <= '0; t4_q <= '0; t5_q <= '0;
      t6_q <= '0; t7_q <= '0; t8_q <= '0; t9_q <= '0;
    end else if (en_i) begin
      t1_q <= t0;   t2_q <= t1_q; t3_q <= t2_q; t4_q <= t4_d; t5_q <= t5_d;
      t6_q <= t5_q; t7_q <= t6_q; t8_q <= t7_q; t9_q <= t8_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        u_q[k]  <= pesu_pkg::DiffW'($signed(p1_i[k])) - pesu_pkg::DiffW'($signed(p0_i[k]));
        w_q[k]  <= pesu_pkg::DiffW'($signed(p2_i[k])) - pesu_pkg::DiffW'($signed(p0_i[k]));
        n1_q[k] <= $signed(p1_i[k]);
        n2_q[k] <= n1_q[k];
      end
      mode1_q <= mode_i;
      mode2_q <= mode1_q;
      // cross product terms
      pr_q[0] <= u_q[1] * w_q[2];
      pr_q[1] <= u_q[2] * w_q[1];
      pr_q[2] <= u_q[2] * w_q[0];
      pr_q[3] <= u_q[0] * w_q[2];
      pr_q[4] <= u_q[0] * w_q[1];
      pr_q[5] <= u_q[1] * w_q[0];
      for (int k = 0; k < 3; k++) begin
        if (mode2_q) begin
          nv_q[k] <= pesu_pkg::NormW'(n2_q[k]);
        end else begin
          nv_q[k] <= pesu_pkg::NormW'(pr_q[2*k]) - pesu_pkg::NormW'(pr_q[2*k+1]);
        end
        if (nv_q[k][pesu_pkg::NormW-1]) begin
          mag4_q[k] <= pesu_pkg::MagW'(-nv_q[k]);
        end else begin
          mag4_q[k] <= pesu_pkg::MagW'(nv_q[k]);
        end
        mag5_q[k] <= mag4_q[k];
        mag6_q[k] <= mag5_q[k];
        sc7_q[k]  <= pesu_pkg::ScW'((mag6_q[k] >> rsh_q) << lsh_q);
        sc8_q[k]  <= sc7_q[k];
        sc9_q[k]  <= sc8_q[k];
        sq_q[k]   <= sc7_q[k] * sc7_q[k];
      end
      max_q <= max_d;
      rsh_q <= rsh_d;
      lsh_q <= lsh_d;
      sum_q <= pesu_pkg::SumW'(sq_q[0]) + pesu_pkg::SumW'(sq_q[1])
             + pesu_pkg::SumW'(sq_q[2]);
    end
  end

  assign tag_o = t9_q;
  assign sum_o = sum_q;
  always_comb begin
    for (int k = 0; k < 3; k++) mag_o[k] = sc9_q[k];
  end

endmodule
`default_nettype wire

FILE: rtl/core/pesu_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module pesu_sqrt (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire pesu_pkg::tag_t                   tag_i,
  input  wire logic [2:0][pesu_pkg::ScW-1:0]    mag_i,
  input  wire logic [pesu_pkg::SumW-1:0]        sum_i,
  output pesu_pkg::tag_t                        tag_o,
  output logic [2:0][pesu_pkg::ScW-1:0]         mag_o,
  output logic [pesu_pkg::RootW-1:0]            root_o
);

  localparam int N = pesu_pkg::RootW;

  pesu_pkg::tag_t                     tag_s [N+1];
  logic [2:0][pesu_pkg::ScW-1:0]      mag_s [N+1];
  logic [pesu_pkg::SumW-1:0]          x_s   [N+1];
  logic [pesu_pkg::ResW-1:0]          res_s [N+1];

  assign tag_s[0] = tag_i;
  assign mag_s[0] = mag_i;
  assign x_s[0]   = sum_i;
  assign res_s[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [pesu_pkg::ResW-1:0] Bit = pesu_pkg::ResW'(1) << (2 * (N - 1 - i));
    logic [pesu_pkg::ResW-1:0] trial;
    logic [pesu_pkg::SumW-1:0] x_d;
    logic [pesu_pkg::ResW-1:0] res_d;

    // one restoring step
    always_comb begin
      trial = res_s[i] + Bit;
      if (pesu_pkg::ResW'(x_s[i]) >= trial) begin
        x_d   = x_s[i] - pesu_pkg::SumW'(trial);
        res_d = (res_s[i] >> 1) + Bit;
      end else begin
        x_d   = x_s[i];
        res_d = res_s[i] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_s[i+1] <= '0;
      end else if (en_i) begin
        tag_s[i+1] <= tag_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mag_s[i+1] <= mag_s[i];
        x_s[i+1]   <= x_d;
        res_s[i+1] <= res_d;
      end
    end
  end

  assign tag_o  = tag_s[N];
  assign mag_o  = mag_s[N];
  assign root_o = res_s[N][pesu_pkg::RootW-1:0];

endmodule
`default_nettype wire

FILE: rtl/core/pesu_div.sv
// Pipelined rounding divider, three lanes, one quotient bit per stage.
`default_nettype none
module pesu_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire pesu_pkg::tag_t                   tag_i,
  input  wire logic [2:0][pesu_pkg::ScW-1:0]    mag_i,
  input  wire logic [pesu_pkg::RootW-1:0]       root_i,
  output pesu_pkg::tag_t                        tag_o,
  output logic [2:0][pesu_pkg::QW-1:0]          quo_o
);

  localparam int N = pesu_pkg::QW;

  pesu_pkg::tag_t                     tag_s [N+1];
  logic [pesu_pkg::DW-1:0]            den_s [N+1];
  logic [2:0][pesu_pkg::RemW-1:0]     rem_s [N+1];
  logic [2:0][pesu_pkg::QW-1:0]       quo_s [N+1];

  // q = (m * 2^(F+1) + L) / (2L), i.e. m * 2^F / L rounded half up
  assign tag_s[0] = tag_i;
  assign den_s[0] = {root_i, 1'b0};
  assign quo_s[0] = '0;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_s[0][k] = (pesu_pkg::RemW'(mag_i[k]) << (pesu_pkg::NormFrac + 1))
                  + pesu_pkg::RemW'(root_i);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int B = N - 1 - i;
    logic [pesu_pkg::RemW-1:0]      dsh;
    logic [2:0][pesu_pkg::RemW-1:0] rem_d;
    logic [2:0][pesu_pkg::QW-1:0]   quo_d;

    always_comb begin
      dsh = pesu_pkg::RemW'(den_s[i]) << B;
      for (int k = 0; k < 3; k++) begin
        rem_d[k] = rem_s[i][k];
        quo_d[k] = quo_s[i][k];
        if (rem_s[i][k] >= dsh) begin
          rem_d[k]    = rem_s[i][k] - dsh;
          quo_d[k][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_s[i+1] <= '0;
      end else if (en_i) begin
        tag_s[i+1] <= tag_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_s[i+1] <= den_s[i];
        rem_s[i+1] <= rem_d;
        quo_s[i+1] <= quo_d;
      end
    end
  end

  assign tag_o = tag_s[N];
  assign quo_o = quo_s[N];

endmodule
`default_nettype wire

FILE: rtl/core/pesu_back.sv
// Back pipeline: coefficient saturation and sign, offset products, offset sum and clamp.
`default_nettype none
module pesu_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire pesu_pkg::tag_t                   tag_i,
  input  wire logic [2:0][pesu_pkg::QW-1:0]     quo_i,
  output logic                                  valid_o,
  output logic [2:0][pesu_pkg::CoefW-1:0]       coef_o,
  output logic [pesu_pkg::OffW-1:0]             off_o,
  output logic                                  deg_o
);

  pesu_pkg::tag_t                     t1_q, t2_q;
  logic                               v3_q;
  logic                               deg3_q;
  logic signed [pesu_pkg::CoefW-1:0]  coef1_q [3];
  logic signed [pesu_pkg::CoefW-1:0]  coef2_q [3];
  logic signed [pesu_pkg::CoefW-1:0]  coef3_q [3];
  logic signed [pesu_pkg::PdW-1:0]    pd_q [3];
  logic signed [pesu_pkg::CoefW-1:0]  coef_d [3];
  logic signed [pesu_pkg::OffSumW-1:0] osum;
  logic [pesu_pkg::OffW-1:0]          off_d, off3_q;

  // clamp magnitude, apply sign, clear on a zero normal
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [pesu_pkg::QW-1:0] q;
      q = (quo_i[k] > pesu_pkg::CoefLimit) ? pesu_pkg::CoefLimit : quo_i[k];
      if (tag_i.deg) begin
        coef_d[k] = '0;
      end else if (tag_i.neg[k]) begin
        coef_d[k] = -$signed(pesu_pkg::CoefW'(q));
      end else begin
        coef_d[k] = $signed(pesu_pkg::CoefW'(q));
      end
    end
  end

  // offset = -(n . p0), clamped to 32 bits
  always_comb begin
    osum = -(pesu_pkg::OffSumW'(pd_q[0]) + pesu_pkg::OffSumW'(pd_q[1])
           + pesu_pkg::OffSumW'(pd_q[2]));
    if (osum > pesu_pkg::OffHi) begin
      off_d = pesu_pkg::OffHi[pesu_pkg::OffW-1:0];
    end else if (osum < pesu_pkg::OffLo) begin
      off_d = pesu_pkg::OffLo[pesu_pkg::OffW-1:0];
    end else begin
      off_d = osum[pesu_pkg::OffW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      t1_q <= tag_i;
      t2_q <= t1_q;
      v3_q <= t2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        coef1_q[k] <= coef_d[k];
        coef2_q[k] <= coef1_q[k];
        coef3_q[k] <= coef2_q[k];
        pd_q[k]    <= coef1_q[k] * $signed(t1_q.p0[k]);
      end
      off3_q <= off_d;
      deg3_q <= t2_q.deg;
    end
  end

  assign valid_o = v3_q;
  assign off_o   = off3_q;
  assign deg_o   = deg3_q;
  always_comb begin
    for (int k = 0; k < 3; k++) coef_o[k] = coef3_q[k];
  end

endmodule
`default_nettype wire

FILE: rtl/core/pesu_checker.sv
// Port-level checker for the plane equation setup unit, bound to the top level.
`default_nettype none
module pesu_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_ready_i,
  input wire logic signed [pesu_pkg::CoefW-1:0]  coef_a_o,
  input wire logic signed [pesu_pkg::CoefW-1:0]  coef_b_o,
  input wire logic signed [pesu_pkg::CoefW-1:0]  coef_c_o,
  input wire logic signed [pesu_pkg::OffW-1:0]   coef_d_o,
  input wire logic                               degenerate_o
);

  // a stalled result stays valid and keeps coef_a, coef_d and degenerate stable
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(coef_d_o)
      && $stable(coef_a_o) && $stable(degenerate_o))
    else $error("stalled result changed");

  // a zero normal gives all-zero coefficients
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> coef_a_o == '0 && coef_b_o == '0
      && coef_c_o == '0 && coef_d_o == '0)
    else $error("degenerate result with nonzero coefficients");

  // coefficients never reach the most negative code
  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> coef_a_o != 16'sh8000 && coef_b_o != 16'sh8000
      && coef_c_o != 16'sh8000)
    else $error("coefficient out of range");

  // input is refused only behind a stalled result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

endmodule

bind plane_equation_setup_unit pesu_checker u_pesu_checker (.*);
`default_nettype wire
